[hw/rtl/qte_pkg.sv]
// Package for the quaternion to Euler angle block.
// Holds widths, the arctangent step table and the CORDIC lane helpers.
// Depends on nothing.
package qte_pkg;

  localparam int unsigned ANGLE_ITERATIONS = 16;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned QW = 16;
  localparam int unsigned PW = 32;
  localparam int unsigned SW = 35;
  localparam int unsigned AW_S = 30;
  localparam int unsigned NW = 57;
  localparam int unsigned SQRT_STAGES = 29;
  localparam int unsigned CW = 38;
  localparam int unsigned AW = 29;
  localparam int unsigned SHW = 5;
  localparam logic signed [AW_S-1:0] ONE_Q28 = AW_S'(1 << 28);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(9000 * 4096);
  localparam logic signed [16:0] LIMIT_XZ = 17'sd18000;
  localparam logic signed [16:0] LIMIT_Y = 17'sd9000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [NW-1:0] res;
  } sqrt_t;

  function automatic logic signed [AW-1:0] atan_step(input logic [SHW-1:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0:  v = AW'(18432000);
      5'd1:  v = AW'(10881045);
      5'd2:  v = AW'(5749245);
      5'd3:  v = AW'(2918407);
      5'd4:  v = AW'(1464867);
      5'd5:  v = AW'(733147);
      5'd6:  v = AW'(366663);
      5'd7:  v = AW'(183343);
      5'd8:  v = AW'(91673);
      5'd9:  v = AW'(45837);
      5'd10: v = AW'(22918);
      5'd11: v = AW'(11459);
      5'd12: v = AW'(5730);
      5'd13: v = AW'(2865);
      5'd14: v = AW'(1432);
      5'd15: v = AW'(716);
      5'd16: v = AW'(358);
      5'd17: v = AW'(179);
      5'd18: v = AW'(90);
      5'd19: v = AW'(45);
      5'd20: v = AW'(22);
      5'd21: v = AW'(11);
      5'd22: v = AW'(6);
      5'd23: v = AW'(3);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic cordic_t cordic_prep(input logic signed [SW-1:0] yv,
                                          input logic signed [SW-1:0] xv);
    cordic_t r;
    r.zero = (xv == '0) && (yv == '0);
    if (xv < 0) begin
      if (yv >= 0) begin
        r.x = CW'(yv);
        r.y = -CW'(xv);
        r.acc = QUARTER_TURN;
      end else begin
        r.x = -CW'(yv);
        r.y = CW'(xv);
        r.acc = -QUARTER_TURN;
      end
    end else begin
      r.x = CW'(xv);
      r.y = CW'(yv);
      r.acc = '0;
    end
    return r;
  endfunction

  function automatic logic signed [16:0] cordic_finish(input cordic_t st,
                                                       input logic signed [16:0] lim);
    logic signed [AW-1:0] rnd;
    logic signed [16:0]   o;
    rnd = st.acc + AW'(2048);
    o = 17'(rnd >>> 12);
    if (o > lim) o = lim;
    if (o < -lim) o = -lim;
    if (st.zero) o = '0;
    return o;
  endfunction

endpackage

[hw/rtl/qte_if.sv]
// Handshake interfaces for quaternion beats and angle beats.
// Depends on qte_pkg for field widths.
interface qte_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qte_pkg::QW-1:0]      quat_w;
  logic signed [qte_pkg::QW-1:0]      quat_x;
  logic signed [qte_pkg::QW-1:0]      quat_y;
  logic signed [qte_pkg::QW-1:0]      quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [14:0] angle_y;
  logic signed [15:0] angle_z;
  logic               pitch_clamped;
  modport source (output valid, angle_x, angle_y, angle_z, pitch_clamped, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, pitch_clamped, output ready);
endinterface

[hw/rtl/qte_sqrt_cell.sv]
// One restoring square root cell: settles one result bit per cycle while en_i is high.
// Depends on qte_pkg.
module qte_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [qte_pkg::NW-1:0]     bit_i,
  input  qte_pkg::sqrt_t             st_i,
  output qte_pkg::sqrt_t             st_o
);
  import qte_pkg::*;

  sqrt_t         st_d, st_q;
  logic [NW:0]   trial;

  always_comb begin
    trial = {1'b0, st_i.res} + {1'b0, bit_i};
    if ({1'b0, st_i.n} >= trial) begin
      st_d.n = st_i.n - trial[NW-1:0];
      st_d.res = (st_i.res >> 1) + bit_i;
    end else begin
      st_d.n = st_i.n;
      st_d.res = st_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;
endmodule

[hw/rtl/qte_cordic_cell.sv]
// One vectoring CORDIC cell: turns the vector toward the x axis once.
// Depends on qte_pkg.
module qte_cordic_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [qte_pkg::SHW-1:0]    shift_i,
  input  qte_pkg::cordic_t           st_i,
  output qte_pkg::cordic_t           st_o
);
  import qte_pkg::*;

  cordic_t              st_d, st_q;
  logic signed [CW-1:0] xs, ys;
  logic signed [AW-1:0] step;

  always_comb begin
    xs = st_i.x >>> shift_i;
    ys = st_i.y >>> shift_i;
    step = atan_step(shift_i);
    st_d.zero = st_i.zero;
    if (st_i.y >= 0) begin
      st_d.x = st_i.x + ys;
      st_d.y = st_i.y - xs;
      st_d.acc = st_i.acc + step;
    end else begin
      st_d.x = st_i.x - ys;
      st_d.y = st_i.y + xs;
      st_d.acc = st_i.acc - step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;
endmodule

[hw/rtl/quaternion_to_euler_angles.sv]
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_if, qte_sqrt_cell and qte_cordic_cell.
//
// One quaternion beat is taken every cycle while the pipeline does not stall, and one angle
// beat leaves for each, in order. The stages are the input register, products, sums, the
// square of the pitch sine, one square root cell per result bit, lane setup, one CORDIC
// cell per iteration and the rounding output register. The whole pipeline stalls only
// while the output beat is held by the sink.
module quaternion_to_euler_angles (
  input  logic        clk_i,
  input  logic        rst_ni,
  qte_in_if.sink      in_i,
  qte_out_if.source   out_o
);
  import qte_pkg::*;

  localparam int unsigned DLY = SQRT_STAGES + 1;
  localparam int unsigned DEPTH = 4 + SQRT_STAGES + 1 + ANGLE_ITERATIONS + 1;

  logic             en;
  logic [DEPTH-1:0] v_q;

  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], in_i.valid};
    end
  end

  logic signed [QW-1:0] w_q, x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= in_i.quat_w;
      x_q <= in_i.quat_x;
      y_q <= in_i.quat_y;
      z_q <= in_i.quat_z;
    end
  end

  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, yz_q, xw_q, xy_q, zw_q, xz_q, yw_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= w_q * w_q;
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      zz_q <= z_q * z_q;
      yz_q <= y_q * z_q;
      xw_q <= x_q * w_q;
      xy_q <= x_q * y_q;
      zw_q <= z_q * w_q;
      xz_q <= x_q * z_q;
      yw_q <= y_q * w_q;
    end
  end

  logic signed [SW-1:0]   yx_d, xx_d, yz_d, xz_d, sr_d;
  logic signed [AW_S-1:0] s_d, s_q;
  logic                   clamp_d;
  logic signed [SW-1:0]   ly_x_q [DLY+1];
  logic signed [SW-1:0]   lx_x_q [DLY+1];
  logic signed [SW-1:0]   ly_z_q [DLY+1];
  logic signed [SW-1:0]   lx_z_q [DLY+1];
  logic signed [AW_S-1:0] s_dl_q [DLY];
  logic                   cl_q   [DLY+1];

  always_comb begin
    yx_d = 2 * (SW'(yz_q) + SW'(xw_q));
    xx_d = SW'(zz_q) + SW'(ww_q) - SW'(xx_q) - SW'(yy_q);
    yz_d = 2 * (SW'(xy_q) + SW'(zw_q));
    xz_d = SW'(xx_q) + SW'(ww_q) - SW'(yy_q) - SW'(zz_q);
    sr_d = -2 * (SW'(xz_q) - SW'(yw_q));
    clamp_d = 1'b0;
    s_d = sr_d[AW_S-1:0];
    if (sr_d > SW'(ONE_Q28)) begin
      s_d = ONE_Q28;
      clamp_d = 1'b1;
    end else if (sr_d < -SW'(ONE_Q28)) begin
      s_d = -ONE_Q28;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ly_x_q[0] <= yx_d;
      lx_x_q[0] <= xx_d;
      ly_z_q[0] <= yz_d;
      lx_z_q[0] <= xz_d;
      s_q <= s_d;
      cl_q[0] <= clamp_d;
      s_dl_q[0] <= s_q;
      for (int k = 1; k <= DLY; k++) begin
        ly_x_q[k] <= ly_x_q[k-1];
        lx_x_q[k] <= lx_x_q[k-1];
        ly_z_q[k] <= ly_z_q[k-1];
        lx_z_q[k] <= lx_z_q[k-1];
        cl_q[k] <= cl_q[k-1];
      end
      for (int k = 1; k < DLY; k++) begin
        s_dl_q[k] <= s_dl_q[k-1];
      end
    end
  end

  logic [2*AW_S-1:0] ssq;
  sqrt_t             sq_q;
  always_comb begin
    ssq = (2*AW_S)'(s_q * s_q);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q.n <= (NW'(1) << 56) - ssq[NW-1:0];
      sq_q.res <= '0;
    end
  end

  sqrt_t sq_st [SQRT_STAGES+1];
  assign sq_st[0] = sq_q;
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .bit_i (NW'(1) << (56 - 2 * k)),
      .st_i  (sq_st[k]),
      .st_o  (sq_st[k+1])
    );
  end

  cordic_t lx_st [ANGLE_ITERATIONS+1];
  cordic_t ly_st [ANGLE_ITERATIONS+1];
  cordic_t lz_st [ANGLE_ITERATIONS+1];
  logic    cl_pre_q;
  logic    cl_line_q [ANGLE_ITERATIONS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_st[0] <= cordic_prep(ly_x_q[DLY], lx_x_q[DLY]);
      lz_st[0] <= cordic_prep(ly_z_q[DLY], lx_z_q[DLY]);
      ly_st[0] <= cordic_prep(SW'(s_dl_q[DLY-1]), SW'(sq_st[SQRT_STAGES].res[AW_S-1:0]));
      cl_pre_q <= cl_q[DLY];
      cl_line_q[0] <= cl_pre_q;
      for (int k = 1; k < ANGLE_ITERATIONS; k++) begin
        cl_line_q[k] <= cl_line_q[k-1];
      end
    end
  end

  for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
    qte_cordic_cell u_x (
      .clk_i (clk_i), .en_i (en), .shift_i (SHW'(k)),
      .st_i (lx_st[k]), .st_o (lx_st[k+1])
    );
    qte_cordic_cell u_y (
      .clk_i (clk_i), .en_i (en), .shift_i (SHW'(k)),
      .st_i (ly_st[k]), .st_o (ly_st[k+1])
    );
    qte_cordic_cell u_z (
      .clk_i (clk_i), .en_i (en), .shift_i (SHW'(k)),
      .st_i (lz_st[k]), .st_o (lz_st[k+1])
    );
  end

  logic signed [16:0] ax, ay, az;
  logic signed [15:0] ax_q, az_q;
  logic signed [14:0] ay_q;
  logic               pc_q;
  always_comb begin
    ax = cordic_finish(lx_st[ANGLE_ITERATIONS], LIMIT_XZ);
    ay = cordic_finish(ly_st[ANGLE_ITERATIONS], LIMIT_Y);
    az = cordic_finish(lz_st[ANGLE_ITERATIONS], LIMIT_XZ);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax[15:0];
      ay_q <= ay[14:0];
      az_q <= az[15:0];
      pc_q <= cl_line_q[ANGLE_ITERATIONS-1];
    end
  end

  assign out_o.valid = v_q[DEPTH-1];
  assign out_o.angle_x = ax_q;
  assign out_o.angle_y = ay_q;
  assign out_o.angle_z = az_q;
  assign out_o.pitch_clamped = pc_q;

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted beat did not enter the pipeline");
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.angle_y <= 15'sd9000 && out_o.angle_y >= -15'sd9000))
    else $error("pitch angle out of range");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(v_q))
    else $error("pipeline moved while output stalled");
endmodule

[tb/qte_tb_if.sv]
// Types shared by the testbench: the expected angle beat.
// The handshake interfaces themselves come from hw/rtl/qte_if.sv; this file
// depends on nothing.
package qte_tb_types;
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [14:0] ay;
    logic signed [15:0] az;
    logic               clamped;
  } euler_t;
endpackage

[tb/quaternion_to_euler_angles_tb.sv]
// Testbench for quaternion_to_euler_angles: directed and random quaternion beats are checked
// against a local CORDIC predictor under several sender idling and receiver stall phases.
// Depends on qte_pkg, qte_if, qte_tb_types and the block's RTL.
module quaternion_to_euler_angles_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qte_tb_types::*;

  localparam int LATENCY = 51;

  logic clk_i = 1'b0;
  logic rst_ni;
  qte_in_if in_if ();
  qte_out_if out_if ();

  quaternion_to_euler_angles uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if));

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  euler_t angles_due[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int clamp_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  longint atan_tab[24] = '{18432000, 10881045, 5749245, 2918407, 1464867, 733147,
                           366663, 183343, 91673, 45837, 22918, 11459, 5730, 2865,
                           1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint yi, longint xi, longint lim);
    longint x, y, acc, t, o;
    if (xi == 0 && yi == 0) return 0;
    if (xi < 0) begin
      if (yi >= 0) begin
        x = yi; y = -xi; acc = 9000 * 4096;
      end else begin
        x = -yi; y = xi; acc = -9000 * 4096;
      end
    end else begin
      x = xi; y = yi; acc = 0;
    end
    for (int i = 0; i < qte_pkg::ANGLE_ITERATIONS && i < 24; i++) begin
      if (y >= 0) begin
        t = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        x = t;
        acc += atan_tab[i];
      end else begin
        t = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        x = t;
        acc -= atan_tab[i];
      end
    end
    o = floor_shift(acc + 2048, 12);
    if (o > lim) o = lim;
    if (o < -lim) o = -lim;
    return o;
  endfunction

  function automatic euler_t predict_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                           logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, s, c;
    euler_t r;
    w = qw; x = qx; y = qy; z = qz;
    r.ax = 16'(vector_angle(2 * (y * z + x * w), -x * x - y * y + z * z + w * w, 18000));
    r.az = 16'(vector_angle(2 * (x * y + z * w), x * x - y * y - z * z + w * w, 18000));
    s = -2 * (x * z - y * w);
    r.clamped = 1'b0;
    if (s > (64'sd1 <<< 28)) begin
      s = 64'sd1 <<< 28; r.clamped = 1'b1;
    end
    if (s < -(64'sd1 <<< 28)) begin
      s = -(64'sd1 <<< 28); r.clamped = 1'b1;
    end
    c = int_sqrt((64'd1 << 56) - longint'(s * s));
    r.ay = 15'(vector_angle(s, c, 9000));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("Mismatch on beat %0d: %s got %0d, expected %0d", beats_checked, what, got, want);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.quat_w = '0;
    in_if.quat_x = '0;
    in_if.quat_y = '0;
    in_if.quat_z = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    euler_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (angles_due.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = angles_due.pop_front();
        if (out_if.angle_x !== e.ax) report_mismatch("angle_x", out_if.angle_x, e.ax);
        if (out_if.angle_y !== e.ay) report_mismatch("angle_y", out_if.angle_y, e.ay);
        if (out_if.angle_z !== e.az) report_mismatch("angle_z", out_if.angle_z, e.az);
        if (out_if.pitch_clamped !== e.clamped)
          report_mismatch("pitch_clamped", out_if.pitch_clamped, e.clamped);
        if (e.clamped) clamp_seen++;
      end
      beats_checked++;
    end
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.quat_w <= w;
    in_if.quat_x <= x;
    in_if.quat_y <= y;
    in_if.quat_z <= z;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    angles_due.push_back(predict_euler(w, x, y, z));
    beats_sent++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(32767));
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h2d41, 16'h0000, 16'h2d41, 16'h0000);
    send_quat(16'h2d41, 16'h0000, 16'hd2bf, 16'h0000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_quat(16'h7fff, 16'h0000, 16'h8000, 16'h0000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'hc000, 16'h0000, 16'h0000, 16'h0001);
    for (int i = 0; i < 6; i++) send_quat(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6]);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(100);
    join
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    send_idle_pct = 80;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    test_random(150);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    drain();
    $display("Sent %0d quaternion beats, checked %0d angle beats, %0d with pitch clamped.",
             beats_sent, beats_checked, clamp_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

[quaternion_to_euler_angles.f]
hw/rtl/qte_pkg.sv
hw/rtl/qte_if.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/quaternion_to_euler_angles.sv
tb/qte_tb_if.sv
tb/quaternion_to_euler_angles_tb.sv
